### hdl/llce_pkg.sv
package llce_pkg;

   localparam int NODES_DEFAULT = 64;
   localparam int TYPE_W        = 5;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 7;

   typedef enum logic [TYPE_W-1:0] {
      OP_CLEAR      = 5'd0,
      OP_INS_FIRST  = 5'd1,
      OP_INS_LAST   = 5'd2,
      OP_GO_FIRST   = 5'd3,
      OP_GO_LAST    = 5'd4,
      OP_RD_FIRST   = 5'd5,
      OP_RD_LAST    = 5'd6,
      OP_DEL_FIRST  = 5'd7,
      OP_DEL_LAST   = 5'd8,
      OP_DEL_AFTER  = 5'd9,
      OP_DEL_BEFORE = 5'd10,
      OP_INS_AFTER  = 5'd11,
      OP_INS_BEFORE = 5'd12,
      OP_RD_CURSOR  = 5'd13,
      OP_WR_CURSOR  = 5'd14,
      OP_NEXT       = 5'd15,
      OP_PREV       = 5'd16
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_READ_B  = 5'b00010,
      ST_WRITE_A = 5'b00100,
      ST_WRITE_B = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;
      logic step_b;
      logic step_wa;
      logic step_wb;
      logic load_out;
   } cmd_type;

endpackage

### hdl/llce_if.sv
interface llce_req_if import llce_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [TYPE_W-1:0]         req_type;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink (input valid, input req_type, input value, output ready);
endinterface

interface llce_rsp_if import llce_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   logic                      error;
   logic                      cursor_valid;
   logic [COUNT_W-1:0]        entry_count;

   modport source (output valid, output read_value, output error, output cursor_valid,
                   output entry_count, input ready);
   modport sink (input valid, input read_value, input error, input cursor_valid,
                 input entry_count, output ready);
endinterface

### hdl/linked_list_cursor_engine.sv
// Each request word is accepted in the idle state and its result word is valid after the result register load.
// One word is in work at a time: a node read, a dependent node read and two write steps
// on the simple dual-port next, prev and value memories, then the result register load.
// A waiting result stalls only the final load, and a new word can be taken while it waits.
// Reset is synchronous and empties the list; node memory contents stay undefined until written.
module linked_list_cursor_engine import llce_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   llce_req_if.sink   req_if,
   llce_rsp_if.source rsp_if
);

   cmd_type cmd;

   llce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   llce_dpath #(.NODES(NODES)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_type     (req_if.req_type),
      .req_value    (req_if.value),
      .read_value   (rsp_if.read_value),
      .error        (rsp_if.error),
      .cursor_valid (rsp_if.cursor_valid),
      .entry_count  (rsp_if.entry_count)
   );

endmodule

### hdl/llce_ram.sv
module llce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

### hdl/llce_dpath.sv
module llce_dpath import llce_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  logic [TYPE_W-1:0]         req_type,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic signed [VALUE_W-1:0] read_value,
   output logic                      error,
   output logic                      cursor_valid,
   output logic [COUNT_W-1:0]        entry_count
);

   localparam int PW = $clog2(NODES + 1);
   localparam int AW = $clog2(NODES);
   localparam logic [PW-1:0] NIL = PW'(NODES);

   function automatic logic [PW-1:0] fix_ptr(input logic [PW-1:0] p);
      return (p < NIL) ? p : NIL;
   endfunction

   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [PW-1:0] fh_ff, fh_in, fresh_ff, fresh_in, count_ff, count_in;
   op_type        op_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [PW-1:0] an_ff, ap_ff, nb_ff;
   logic signed [VALUE_W-1:0] rv_ff, rd_ff, rd_in;
   logic          err_ff, err_in;

   logic [PW-1:0]      nx_rdata, pv_rdata;
   logic [VALUE_W-1:0] vl_rdata;
   logic [PW-1:0]      nx_raddr, pv_raddr, vl_raddr;
   logic               nx_we, pv_we, vl_we;
   logic [PW-1:0]      nx_waddr, pv_waddr, vl_waddr;
   logic [PW-1:0]      nx_wdata, pv_wdata;
   logic [VALUE_W-1:0] vl_wdata;

   op_type        op_new;
   logic [PW-1:0] nb, pb, n_sel, d_sel;
   logic          full, is_ins, ins_go, ins_do;
   logic          del_first_do, del_last_do, del_after_do, del_before_do, del_do;

   assign op_new = op_type'(req_type);
   assign nb     = fix_ptr(nx_rdata);
   assign pb     = fix_ptr(pv_rdata);

   always_comb begin
      if (fh_ff != NIL) begin
         n_sel = fh_ff;
      end else if (fresh_ff < NIL) begin
         n_sel = fresh_ff;
      end else begin
         n_sel = NIL;
      end
   end

   assign full   = (n_sel == NIL);
   assign is_ins = (op_ff == OP_INS_FIRST) || (op_ff == OP_INS_LAST) ||
                   (op_ff == OP_INS_AFTER) || (op_ff == OP_INS_BEFORE);
   assign ins_go = (op_ff == OP_INS_FIRST) || (op_ff == OP_INS_LAST) || (cur_ff != NIL);
   assign ins_do = is_ins && ins_go && !full;

   assign del_first_do  = (op_ff == OP_DEL_FIRST) && (head_ff != NIL);
   assign del_last_do   = (op_ff == OP_DEL_LAST) && (head_ff != NIL) && (tail_ff != NIL);
   assign del_after_do  = (op_ff == OP_DEL_AFTER) && (cur_ff != NIL) && (cur_ff != tail_ff) &&
                          (an_ff != NIL);
   assign del_before_do = (op_ff == OP_DEL_BEFORE) && (cur_ff != NIL) && (cur_ff != head_ff) &&
                          (ap_ff != NIL);
   assign del_do = del_first_do || del_last_do || del_after_do || del_before_do;

   always_comb begin
      priority if (del_first_do) begin
         d_sel = head_ff;
      end else if (del_last_do) begin
         d_sel = tail_ff;
      end else if (del_after_do) begin
         d_sel = an_ff;
      end else begin
         d_sel = ap_ff;
      end
   end

   // The first read is issued with the accepted word, the second one follows the first result.
   always_comb begin
      if (cmd.accept) begin
         unique case (op_new)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEFORE: nx_raddr = fh_ff;
            OP_DEL_FIRST: nx_raddr = head_ff;
            default:      nx_raddr = cur_ff;
         endcase
         pv_raddr = (op_new == OP_DEL_LAST) ? tail_ff : cur_ff;
         unique case (op_new)
            OP_RD_FIRST: vl_raddr = head_ff;
            OP_RD_LAST:  vl_raddr = tail_ff;
            default:     vl_raddr = cur_ff;
         endcase
      end else begin
         nx_raddr = (op_ff == OP_INS_AFTER) ? cur_ff : nb;
         pv_raddr = pb;
         vl_raddr = cur_ff;
      end
   end

   always_comb begin
      nx_we    = 1'b0;
      nx_waddr = n_sel;
      nx_wdata = NIL;
      pv_we    = 1'b0;
      pv_waddr = n_sel;
      pv_wdata = NIL;
      vl_we    = 1'b0;
      vl_waddr = n_sel;
      vl_wdata = val_ff;
      if (cmd.step_wa) begin
         unique case (op_ff)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEFORE: begin
               vl_we = ins_do;
               nx_we = ins_do;
               pv_we = ins_do;
               unique case (op_ff)
                  OP_INS_FIRST: begin
                     nx_wdata = head_ff;
                  end
                  OP_INS_LAST: begin
                     pv_wdata = tail_ff;
                  end
                  OP_INS_AFTER: begin
                     pv_wdata = cur_ff;
                     nx_wdata = nb;
                  end
                  default: begin
                     nx_wdata = cur_ff;
                     pv_wdata = ap_ff;
                  end
               endcase
            end
            OP_DEL_FIRST: begin
               pv_we    = del_first_do && (head_ff != tail_ff) && (an_ff != NIL);
               pv_waddr = an_ff;
            end
            OP_DEL_LAST: begin
               nx_we    = del_last_do && (tail_ff != head_ff) && (ap_ff != NIL);
               nx_waddr = ap_ff;
            end
            OP_DEL_AFTER: begin
               nx_we    = del_after_do;
               nx_waddr = cur_ff;
               nx_wdata = (an_ff == tail_ff) ? NIL : nb;
               pv_we    = del_after_do && (an_ff != tail_ff) && (nb != NIL);
               pv_waddr = nb;
               pv_wdata = cur_ff;
            end
            OP_DEL_BEFORE: begin
               pv_we    = del_before_do;
               pv_waddr = cur_ff;
               pv_wdata = (ap_ff == head_ff) ? NIL : pb;
               nx_we    = del_before_do && (ap_ff != head_ff) && (pb != NIL);
               nx_waddr = pb;
               nx_wdata = cur_ff;
            end
            OP_WR_CURSOR: begin
               vl_we    = (cur_ff != NIL);
               vl_waddr = cur_ff;
            end
            default: begin
            end
         endcase
      end else if (cmd.step_wb) begin
         unique case (op_ff)
            OP_INS_FIRST: begin
               pv_we    = ins_do && (head_ff != NIL);
               pv_waddr = head_ff;
               pv_wdata = n_sel;
            end
            OP_INS_LAST: begin
               nx_we    = ins_do && (tail_ff != NIL);
               nx_waddr = tail_ff;
               nx_wdata = n_sel;
            end
            OP_INS_AFTER: begin
               nx_we    = ins_do;
               nx_waddr = cur_ff;
               nx_wdata = n_sel;
               pv_we    = ins_do && (cur_ff != tail_ff) && (nb_ff != NIL);
               pv_waddr = nb_ff;
               pv_wdata = n_sel;
            end
            OP_INS_BEFORE: begin
               pv_we    = ins_do;
               pv_waddr = cur_ff;
               pv_wdata = n_sel;
               nx_we    = ins_do && (cur_ff != head_ff) && (ap_ff != NIL);
               nx_waddr = ap_ff;
               nx_wdata = n_sel;
            end
            default: begin
               nx_we    = del_do;
               nx_waddr = d_sel;
               nx_wdata = fh_ff;
            end
         endcase
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      cur_in   = cur_ff;
      fh_in    = fh_ff;
      fresh_in = fresh_ff;
      count_in = count_ff;
      rd_in    = '0;
      err_in   = 1'b0;
      if (ins_do) begin
         count_in = count_ff + 1'b1;
         if (fh_ff != NIL) begin
            fh_in = an_ff;
         end else begin
            fresh_in = fresh_ff + 1'b1;
         end
      end
      if (del_do) begin
         fh_in = d_sel;
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end
      unique case (op_ff)
         OP_CLEAR: begin
            head_in  = NIL;
            tail_in  = NIL;
            cur_in   = NIL;
            fh_in    = NIL;
            fresh_in = '0;
            count_in = '0;
         end
         OP_INS_FIRST: begin
            err_in = full;
            if (ins_do) begin
               head_in = n_sel;
               if (head_ff == NIL) begin
                  tail_in = n_sel;
               end
            end
         end
         OP_INS_LAST: begin
            err_in = full;
            if (ins_do) begin
               tail_in = n_sel;
               if (tail_ff == NIL) begin
                  head_in = n_sel;
               end
            end
         end
         OP_INS_AFTER: begin
            err_in = ins_go && full;
            if (ins_do && (cur_ff == tail_ff)) begin
               tail_in = n_sel;
            end
         end
         OP_INS_BEFORE: begin
            err_in = ins_go && full;
            if (ins_do && (cur_ff == head_ff)) begin
               head_in = n_sel;
            end
         end
         OP_GO_FIRST: cur_in = head_ff;
         OP_GO_LAST:  cur_in = tail_ff;
         OP_RD_FIRST, OP_RD_LAST: begin
            err_in = (head_ff == NIL) || (tail_ff == NIL);
            rd_in  = err_in ? '0 : rv_ff;
         end
         OP_RD_CURSOR: begin
            err_in = (cur_ff == NIL);
            rd_in  = err_in ? '0 : rv_ff;
         end
         OP_DEL_FIRST: begin
            if (del_first_do) begin
               if (head_ff == cur_ff) begin
                  cur_in = NIL;
               end
               if (head_ff == tail_ff) begin
                  head_in = NIL;
                  tail_in = NIL;
               end else begin
                  head_in = an_ff;
               end
            end
         end
         OP_DEL_LAST: begin
            if (del_last_do) begin
               if (tail_ff == cur_ff) begin
                  cur_in = NIL;
               end
               if (tail_ff == head_ff) begin
                  head_in = NIL;
                  tail_in = NIL;
               end else begin
                  tail_in = ap_ff;
               end
            end
         end
         OP_DEL_AFTER: begin
            if (del_after_do && (an_ff == tail_ff)) begin
               tail_in = cur_ff;
            end
         end
         OP_DEL_BEFORE: begin
            if (del_before_do && (ap_ff == head_ff)) begin
               head_in = cur_ff;
            end
         end
         OP_NEXT: begin
            if (cur_ff != NIL) begin
               cur_in = an_ff;
            end
         end
         OP_PREV: begin
            if (cur_ff != NIL) begin
               cur_in = ap_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= NIL;
         tail_ff  <= NIL;
         cur_ff   <= NIL;
         fh_ff    <= NIL;
         fresh_ff <= '0;
         count_ff <= '0;
      end else if (cmd.step_wb) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cur_ff   <= cur_in;
         fh_ff    <= fh_in;
         fresh_ff <= fresh_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_new;
         val_ff <= req_value;
      end
      if (cmd.step_b) begin
         an_ff <= nb;
         ap_ff <= pb;
         rv_ff <= vl_rdata;
      end
      if (cmd.step_wa) begin
         nb_ff <= nb;
      end
      if (cmd.step_wb) begin
         rd_ff  <= rd_in;
         err_ff <= err_in;
      end
      if (cmd.load_out) begin
         read_value   <= rd_ff;
         error        <= err_ff;
         cursor_valid <= (cur_ff != NIL);
         entry_count  <= COUNT_W'(count_ff);
      end
   end

   llce_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next_ram (
      .clock (clock),
      .we    (nx_we),
      .waddr (nx_waddr[AW-1:0]),
      .wdata (nx_wdata),
      .raddr (nx_raddr[AW-1:0]),
      .rdata (nx_rdata)
   );

   llce_ram #(.WIDTH(PW), .DEPTH(NODES)) u_prev_ram (
      .clock (clock),
      .we    (pv_we),
      .waddr (pv_waddr[AW-1:0]),
      .wdata (pv_wdata),
      .raddr (pv_raddr[AW-1:0]),
      .rdata (pv_rdata)
   );

   llce_ram #(.WIDTH(VALUE_W), .DEPTH(NODES)) u_value_ram (
      .clock (clock),
      .we    (vl_we),
      .waddr (vl_waddr[AW-1:0]),
      .wdata (vl_wdata),
      .raddr (vl_raddr[AW-1:0]),
      .rdata (vl_rdata)
   );

endmodule

### hdl/llce_ctrl.sv
module llce_ctrl import llce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ_B;
            end
         end
         ST_READ_B: begin
            cmd.step_b = 1'b1;
            state_in   = ST_WRITE_A;
         end
         ST_WRITE_A: begin
            cmd.step_wa = 1'b1;
            state_in    = ST_WRITE_B;
         end
         ST_WRITE_B: begin
            cmd.step_wb = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/llce_checker.sv
module llce_checker import llce_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_read_value,
   input logic                      rsp_error,
   input logic                      rsp_cursor_valid,
   input logic [COUNT_W-1:0]        rsp_entry_count
);

   // A stalled result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_error))
      else $error("stalled result word changed");

   // Only one word is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_read_value == '0)
      else $error("failed request returned a value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cursor_valid && (NODES < 128) |-> rsp_entry_count != '0)
      else $error("active cursor on an empty list");

endmodule

bind linked_list_cursor_engine llce_checker #(.NODES(NODES)) u_llce_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_read_value   (rsp_if.read_value),
   .rsp_error        (rsp_if.error),
   .rsp_cursor_valid (rsp_if.cursor_valid),
   .rsp_entry_count  (rsp_if.entry_count)
);
